// ===== hdl/pca_pkg.sv =====
package pca_pkg;

    localparam int MAX_DIM_DEF     = 8;
    localparam int STORE_DEPTH_DEF = 36;

    localparam int CMD_W     = 2;
    localparam int X_W       = 16;
    localparam int W_W       = 16;
    localparam int IDX_W     = 6;
    localparam int ENTRY_W   = 48;
    localparam int RES_W     = 64;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ACCUM = 2'd1,
        CMD_QUAD  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_DIM  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG = 1'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic signed [RES_W-1:0]   MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [RES_W-1:0]   MIN64 = 64'sh8000_0000_0000_0000;
    localparam logic signed [ENTRY_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ENTRY_W-1:0] MIN48 = 48'sh8000_0000_0000;

    typedef struct packed {
        logic                    sat;
        logic signed [RES_W-1:0] val;
    } sat_sum_t;

    function automatic sat_sum_t sat_add64(input logic signed [RES_W-1:0] a,
                                           input logic signed [RES_W-1:0] b);
        sat_sum_t                r;
        logic signed [RES_W-1:0] s;
        s     = a + b;
        r.sat = (a[RES_W-1] == b[RES_W-1]) && (s[RES_W-1] != a[RES_W-1]);
        r.val = r.sat ? (a[RES_W-1] ? MIN64 : MAX64) : s;
        return r;
    endfunction

endpackage

// ===== hdl/pca_if.sv =====
interface pca_item_if;
    logic                                valid;
    logic                                ready;
    pca_pkg::cmd_t                       command;
    logic signed [pca_pkg::X_W-1:0]      element_value;
    logic        [pca_pkg::W_W-1:0]      weight;
    logic        [pca_pkg::IDX_W-1:0]    entry_index;

    modport source (output valid, command, element_value, weight, entry_index,
                    input ready);
    modport sink   (input valid, command, element_value, weight, entry_index,
                    output ready);
endinterface

interface pca_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pca_pkg::RES_W-1:0]    result_value;
    logic                                result_kind;
    logic                                saturated;

    modport source (output valid, result_value, result_kind, saturated, input ready);
    modport sink   (input valid, result_value, result_kind, saturated, output ready);
endinterface

interface pca_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pca_pkg::CFG_IDX_W-1:0]       index;
    logic [pca_pkg::ENTRY_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pca_store.sv =====
module pca_store #(
    parameter  int DEPTH = pca_pkg::STORE_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [pca_pkg::ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [pca_pkg::ENTRY_W-1:0] rdata
);

    logic [pca_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [pca_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/packed_covariance_accumulator.sv =====
// Accumulate / quadratic element at row p: p+1 store accesses on the single read port
// of the matrix store, then a read-multiply-write drain, before the next beat is taken.
// Last quadratic element: sums combined in ST_FIN1, ST_FIN2; result loaded in ST_EMIT.
// Read entry: ST_RDISSUE, ST_RDWAIT, then ST_EMIT loads the result; the next beat follows.
// Clear: rewrites the first min(STORE_DEPTH, MAX_DIM*(MAX_DIM+1)/2) store entries.
// After rst_n all STORE_DEPTH store entries are zeroed, one entry per cycle, no beats taken.
module packed_covariance_accumulator #(
    parameter int MAX_DIM     = pca_pkg::MAX_DIM_DEF,
    parameter int STORE_DEPTH = pca_pkg::STORE_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    pca_item_if.sink     item,
    pca_result_if.source result,
    pca_cfg_if.sink      cfg
);

    localparam int TRI      = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int PW       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int RW       = (TRI > 1) ? $clog2(TRI) : 1;
    localparam int AW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int DW0      = $clog2(MAX_DIM + 1);
    localparam int DW       = (DW0 > pca_pkg::DIM_W) ? DW0 : pca_pkg::DIM_W;
    localparam int CW0      = (RW > AW) ? RW : AW;
    localparam int CW       = ((CW0 > pca_pkg::IDX_W) ? CW0 : pca_pkg::IDX_W) + 1;
    localparam int CLR_LAST = ((STORE_DEPTH < TRI) ? STORE_DEPTH : TRI) - 1;
    localparam int EW       = pca_pkg::ENTRY_W;
    localparam int XW       = pca_pkg::X_W;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FIN1,
        ST_FIN2,
        ST_RDISSUE,
        ST_RDWAIT,
        ST_EMIT
    } state_t;

    state_t                               state_reg;
    logic [pca_pkg::DIM_W-1:0]            dim_reg;
    logic signed [EW-1:0]                 diag_reg;

    pca_pkg::cmd_t                        cmd_reg;
    logic signed [XW-1:0]                 x_reg;
    logic [pca_pkg::W_W-1:0]              w_reg;
    logic [pca_pkg::IDX_W-1:0]            idx_reg;
    logic                                 last_reg;
    logic [PW-1:0]                        pos_reg;
    logic [RW-1:0]                        base_reg;
    logic [PW-1:0]                        q_reg;

    logic [AW-1:0]                        sw_addr_reg;
    logic [PW-1:0]                        sw_col_reg;
    logic [PW-1:0]                        sw_row_reg;
    logic                                 sw_clear_reg;

    logic signed [pca_pkg::RES_W-1:0]     diag_sum_reg;
    logic signed [pca_pkg::RES_W-1:0]     off_sum_reg;
    logic                                 sat_reg;
    logic signed [pca_pkg::RES_W-1:0]     twice_reg;
    logic                                 fin_sat_reg;
    logic signed [pca_pkg::RES_W-1:0]     res_value_reg;
    logic                                 res_kind_reg;
    logic                                 res_sat_reg;
    logic                                 out_valid_reg;
    logic signed [pca_pkg::RES_W-1:0]     out_value_reg;
    logic                                 out_kind_reg;
    logic                                 out_sat_reg;

    // element buffer, written once per element beat
    logic signed [XW-1:0]                 vbuf [MAX_DIM];

    // read-modify-write pipeline
    logic                                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                                 d1_reg, d2_reg, d3_reg, d4_reg;
    logic                                 inr1_reg, inr2_reg;
    logic [AW-1:0]                        addr1_reg, addr2_reg;
    logic signed [31:0]                   xx1_reg;
    logic signed [EW-1:0]                 e2_reg;
    logic signed [EW:0]                   m2_reg;
    logic [30:0]                          ua2_reg;
    logic [EW-1:0]                        ub2_reg;
    logic                                 neg2_reg, neg3_reg;
    logic [54:0]                          ph3_reg, pl3_reg;
    logic signed [pca_pkg::RES_W-1:0]     term4_reg;
    logic                                 tsat4_reg;

    logic [RW-1:0]                        r_s0;
    logic [CW-1:0]                        r_ext;
    logic [CW-1:0]                        idx_ext;
    logic                                 inr_s0;
    logic                                 idx_inr;
    logic [DW-1:0]                        dim_ext;
    logic [DW-1:0]                        eff_dim;
    logic                                 elem_last;

    logic                                 mem_we;
    logic [AW-1:0]                        mem_waddr;
    logic [EW-1:0]                        mem_wdata;
    logic [AW-1:0]                        mem_raddr;
    logic [EW-1:0]                        mem_rdata;

    logic signed [EW-1:0]                 e_s1;
    logic signed [31:0]                   ua_full;
    logic signed [EW-1:0]                 ub_full;
    logic signed [32:0]                   t_s2;
    logic signed [EW+1:0]                 acc_sum;
    logic signed [EW-1:0]                 acc_sat;
    logic                                 big_s3;
    logic [63:0]                          tot_s3;
    logic                                 over_s3;
    logic signed [pca_pkg::RES_W-1:0]     term_s3;
    logic                                 sweep_done;

    pca_pkg::sat_sum_t                    s4_add;
    pca_pkg::sat_sum_t                    fin1_add;
    pca_pkg::sat_sum_t                    fin2_add;

    // ---------------------------------------------------------------- addressing
    assign r_s0    = base_reg + RW'(q_reg);
    assign r_ext   = CW'(r_s0);
    assign idx_ext = CW'(idx_reg);
    assign inr_s0  = r_ext < CW'(STORE_DEPTH);
    assign idx_inr = idx_ext < CW'(STORE_DEPTH);

    // dim 0 behaves as 1, anything above MAX_DIM as MAX_DIM
    assign dim_ext   = DW'(dim_reg);
    assign eff_dim   = (dim_reg == '0) ? DW'(1) :
                       ((dim_ext > DW'(MAX_DIM)) ? DW'(MAX_DIM) : dim_ext);
    assign elem_last = (DW'(pos_reg) + DW'(1)) >= eff_dim;

    assign sweep_done = sw_clear_reg ? (sw_addr_reg == AW'(CLR_LAST))
                                     : (sw_addr_reg == AW'(STORE_DEPTH - 1));

    // ---------------------------------------------------------------- store
    assign mem_raddr = (state_reg == ST_RDISSUE) ? idx_ext[AW-1:0] : r_ext[AW-1:0];
    assign mem_we    = (state_reg == ST_SWEEP) ||
                       (v2_reg && inr2_reg && cmd_reg == pca_pkg::CMD_ACCUM);
    assign mem_waddr = (state_reg == ST_SWEEP) ? sw_addr_reg : addr2_reg;
    assign mem_wdata = (state_reg == ST_SWEEP)
                     ? ((sw_clear_reg && sw_col_reg == sw_row_reg) ? diag_reg : '0)
                     : acc_sat;

    pca_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------------------------------------------------------- datapath
    assign e_s1    = inr1_reg ? $signed(mem_rdata) : '0;
    assign ua_full = xx1_reg[31] ? -xx1_reg : xx1_reg;
    assign ub_full = e_s1[EW-1] ? -e_s1 : e_s1;

    // floor shift of the Q.40 term down to Q24.24, then saturating add
    assign t_s2    = m2_reg[EW:16];
    assign acc_sum = {{2{e2_reg[EW-1]}}, e2_reg} + {{(EW-31){t_s2[32]}}, t_s2};
    assign acc_sat = (acc_sum[EW+1:EW-1] == 3'b000 || acc_sum[EW+1:EW-1] == 3'b111)
                   ? acc_sum[EW-1:0]
                   : (acc_sum[EW+1] ? pca_pkg::MIN48 : pca_pkg::MAX48);

    // magnitude product, split at bit 24 of the entry magnitude
    assign big_s3  = ph3_reg[54:39] != '0;
    assign tot_s3  = {ph3_reg[38:0], 24'd0} + {9'd0, pl3_reg};
    assign over_s3 = big_s3 || (neg3_reg ? (tot_s3[63] && tot_s3[62:0] != '0) : tot_s3[63]);
    assign term_s3 = over_s3 ? (neg3_reg ? pca_pkg::MIN64 : pca_pkg::MAX64)
                             : (neg3_reg ? $signed(-tot_s3) : $signed(tot_s3));

    assign s4_add   = pca_pkg::sat_add64(d4_reg ? diag_sum_reg : off_sum_reg, term4_reg);
    assign fin1_add = pca_pkg::sat_add64(off_sum_reg, off_sum_reg);
    assign fin2_add = pca_pkg::sat_add64(diag_sum_reg, twice_reg);

    always_ff @(posedge clk)
    begin
        if (item.valid && state_reg == ST_IDLE &&
            (item.command inside {pca_pkg::CMD_ACCUM, pca_pkg::CMD_QUAD}))
        begin
            vbuf[pos_reg] <= item.element_value;
        end
        d1_reg    <= (q_reg == pos_reg);
        inr1_reg  <= inr_s0;
        addr1_reg <= r_ext[AW-1:0];
        xx1_reg   <= x_reg * vbuf[q_reg];

        d2_reg    <= d1_reg;
        inr2_reg  <= inr1_reg;
        addr2_reg <= addr1_reg;
        e2_reg    <= e_s1;
        m2_reg    <= xx1_reg * $signed({1'b0, w_reg});
        ua2_reg   <= ua_full[30:0];
        ub2_reg   <= ub_full;
        neg2_reg  <= xx1_reg[31] ^ e_s1[EW-1];

        d3_reg    <= d2_reg;
        ph3_reg   <= ua2_reg * ub2_reg[EW-1:24];
        pl3_reg   <= ua2_reg * ub2_reg[23:0];
        neg3_reg  <= neg2_reg;

        d4_reg    <= d3_reg;
        term4_reg <= term_s3;
        tsat4_reg <= over_s3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (state_reg == ST_ISSUE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            dim_reg       <= pca_pkg::DIM_RESET;
            diag_reg      <= '0;
            cmd_reg       <= pca_pkg::CMD_CLEAR;
            x_reg         <= '0;
            w_reg         <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            pos_reg       <= '0;
            base_reg      <= '0;
            q_reg         <= '0;
            sw_addr_reg   <= '0;
            sw_col_reg    <= '0;
            sw_row_reg    <= '0;
            sw_clear_reg  <= 1'b0;
            diag_sum_reg  <= '0;
            off_sum_reg   <= '0;
            sat_reg       <= 1'b0;
            twice_reg     <= '0;
            fin_sat_reg   <= 1'b0;
            res_value_reg <= '0;
            res_kind_reg  <= 1'b0;
            res_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_kind_reg  <= 1'b0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    pca_pkg::REG_DIM:  dim_reg  <= cfg.data[pca_pkg::DIM_W-1:0];
                    pca_pkg::REG_DIAG: diag_reg <= cfg.data;
                    default: ;
                endcase
            end

            // in ST_EMIT the output register is reloaded below instead
            if (out_valid_reg && result.ready && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            if (v4_reg && cmd_reg == pca_pkg::CMD_QUAD)
            begin
                if (d4_reg)
                begin
                    diag_sum_reg <= s4_add.val;
                end
                else
                begin
                    off_sum_reg <= s4_add.val;
                end
                sat_reg <= sat_reg | tsat4_reg | s4_add.sat;
            end

            case (state_reg)
                ST_SWEEP:
                begin
                    if (sw_col_reg == sw_row_reg)
                    begin
                        sw_row_reg <= sw_row_reg + PW'(1);
                        sw_col_reg <= '0;
                    end
                    else
                    begin
                        sw_col_reg <= sw_col_reg + PW'(1);
                    end
                    sw_addr_reg <= sw_addr_reg + AW'(1);
                    if (sweep_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (item.valid)
                    begin
                        case (item.command)
                            pca_pkg::CMD_CLEAR:
                            begin
                                sw_clear_reg <= 1'b1;
                                sw_addr_reg  <= '0;
                                sw_col_reg   <= '0;
                                sw_row_reg   <= '0;
                                pos_reg      <= '0;
                                base_reg     <= '0;
                                diag_sum_reg <= '0;
                                off_sum_reg  <= '0;
                                sat_reg      <= 1'b0;
                                state_reg    <= ST_SWEEP;
                            end
                            pca_pkg::CMD_READ:
                            begin
                                idx_reg   <= item.entry_index;
                                state_reg <= ST_RDISSUE;
                            end
                            default:
                            begin
                                cmd_reg   <= item.command;
                                x_reg     <= item.element_value;
                                w_reg     <= item.weight;
                                last_reg  <= elem_last;
                                q_reg     <= '0;
                                state_reg <= ST_ISSUE;
                            end
                        endcase
                    end
                end
                ST_ISSUE:
                begin
                    if (q_reg == pos_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        q_reg <= q_reg + PW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!(v1_reg || v2_reg || v3_reg || v4_reg))
                    begin
                        if (!last_reg)
                        begin
                            pos_reg   <= pos_reg + PW'(1);
                            base_reg  <= base_reg + RW'(pos_reg) + RW'(1);
                            state_reg <= ST_IDLE;
                        end
                        else if (cmd_reg == pca_pkg::CMD_QUAD)
                        begin
                            state_reg <= ST_FIN1;
                        end
                        else
                        begin
                            pos_reg      <= '0;
                            base_reg     <= '0;
                            diag_sum_reg <= '0;
                            off_sum_reg  <= '0;
                            sat_reg      <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end
                ST_FIN1:
                begin
                    twice_reg   <= fin1_add.val;
                    fin_sat_reg <= sat_reg | fin1_add.sat;
                    state_reg   <= ST_FIN2;
                end
                ST_FIN2:
                begin
                    res_value_reg <= fin2_add.val;
                    res_kind_reg  <= 1'b0;
                    res_sat_reg   <= fin_sat_reg | fin2_add.sat;
                    pos_reg       <= '0;
                    base_reg      <= '0;
                    diag_sum_reg  <= '0;
                    off_sum_reg   <= '0;
                    sat_reg       <= 1'b0;
                    state_reg     <= ST_EMIT;
                end
                ST_RDISSUE:
                begin
                    state_reg <= ST_RDWAIT;
                end
                ST_RDWAIT:
                begin
                    res_value_reg <= idx_inr ? {{(pca_pkg::RES_W-EW){mem_rdata[EW-1]}}, mem_rdata}
                                             : '0;
                    res_kind_reg  <= 1'b1;
                    res_sat_reg   <= 1'b0;
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= res_value_reg;
                        out_kind_reg  <= res_kind_reg;
                        out_sat_reg   <= res_sat_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item.ready          = (state_reg == ST_IDLE);
    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.result_value = out_value_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.saturated    = out_sat_reg;

    // ---------------------------------------------------------------- checks
    a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !(v1_reg || v2_reg || v3_reg || v4_reg))
        else $error("beat taken while store pipeline busy");

    a_issue_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> (q_reg <= pos_reg))
        else $error("column counter ran past the row");

    a_vector_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN2) |=> (pos_reg == '0 && base_reg == '0 &&
                                    diag_sum_reg == '0 && off_sum_reg == '0 && !sat_reg))
        else $error("vector state not cleared after quadratic result");

    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (CW'(sw_addr_reg) < CW'(STORE_DEPTH)))
        else $error("sweep address beyond store");

endmodule
